### rtl/core/spfd_pkg.sv
// ----------------------------------------------------------------------------
// spfd_pkg - shared types and constants for the 2D spring force block
// Widths of the position path, register codes and the front-to-back item.
// ----------------------------------------------------------------------------
`default_nettype none

package spfd_pkg;

    localparam int POS_W         = 32;
    localparam int DELTA_W       = POS_W + 1;           // |B - A| per axis
    localparam int RAD_W         = 2 * DELTA_W;         // dx^2 + dy^2
    localparam int ROOT_W        = RAD_W / 2;           // distance d
    localparam int REM_W         = ROOT_W + 3;          // root remainder
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_W         = 32;
    localparam int FRAC_BITS_DEF = 16;
    localparam int FIFO_DEPTH    = 4;

    localparam logic [CFG_IDX_W-1:0] REG_STIFFNESS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REST_LENGTH = 2'd1;

    // One classified item handed from the front to the back
    typedef struct packed {
        logic [RAD_W-1:0]   rad;
        logic [DELTA_W-1:0] adx;
        logic [DELTA_W-1:0] ady;
        logic               negx;
        logic               negy;
        logic               att;
    } spfd_item_t;

endpackage

`default_nettype wire

### rtl/core/spring_force_2d.sv
// ----------------------------------------------------------------------------
// spring_force_2d - Hooke spring impulse between two bodies in the plane
// Top level: configuration registers, front, queue and force pipeline.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one beat of two positions and the
//   both_attached flag. Output channel (out_valid/out_ready) gives one beat of
//   four impulses and applied for every input beat, in order.
//   Configuration channel (cfg_valid/cfg_ready, always ready) writes
//   stiffness (index 0) or rest_length (index 1); other indexes are ignored.
//   Write configuration only while no beat is in flight.
//   The square root has 33 stages and the dividers FRAC_BITS+1 stages each.
//   Throughput is one beat per cycle when nothing stalls (fully pipelined).
//   When the receiver stalls, the back pipeline holds; a four-deep queue
//   absorbs front beats, then in_ready drops.
//   Reset clears all valid state and loads stiffness = 1.0, rest_length = 0.
// ----------------------------------------------------------------------------
`default_nettype none

module spring_force_2d #(
    parameter int FRAC_BITS = spfd_pkg::FRAC_BITS_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [spfd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [spfd_pkg::CFG_W-1:0]           cfg_data,
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic signed [spfd_pkg::POS_W-1:0]    pos_a_x,
    input  wire logic signed [spfd_pkg::POS_W-1:0]    pos_a_y,
    input  wire logic signed [spfd_pkg::POS_W-1:0]    pos_b_x,
    input  wire logic signed [spfd_pkg::POS_W-1:0]    pos_b_y,
    input  wire logic                                 both_attached,
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic signed [spfd_pkg::POS_W-1:0]         impulse_a_x,
    output logic signed [spfd_pkg::POS_W-1:0]         impulse_a_y,
    output logic signed [spfd_pkg::POS_W-1:0]         impulse_b_x,
    output logic signed [spfd_pkg::POS_W-1:0]         impulse_b_y,
    output logic                                      applied
);
    import spfd_pkg::*;

    localparam logic [CFG_W-1:0] STIFF_RESET = CFG_W'(1) << FRAC_BITS;

    logic [CFG_W-1:0] stiffness_reg, rest_length_reg;
    logic             push_valid, push_ready, pop_valid, pop_ready;
    spfd_item_t       push_item, pop_item;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stiffness_reg   <= STIFF_RESET;
            rest_length_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_STIFFNESS:   stiffness_reg   <= cfg_data;
                REG_REST_LENGTH: rest_length_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    spfd_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .pos_a_x       (pos_a_x),
        .pos_a_y       (pos_a_y),
        .pos_b_x       (pos_b_x),
        .pos_b_y       (pos_b_y),
        .both_attached (both_attached),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .push_item     (push_item)
    );

    spfd_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    spfd_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (pop_valid),
        .in_ready    (pop_ready),
        .in_item     (pop_item),
        .stiffness   (stiffness_reg),
        .rest_length (rest_length_reg),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .impulse_a_x (impulse_a_x),
        .impulse_a_y (impulse_a_y),
        .impulse_b_x (impulse_b_x),
        .impulse_b_y (impulse_b_y),
        .applied     (applied)
    );

endmodule

`default_nettype wire

### rtl/core/spfd_front.sv
// ----------------------------------------------------------------------------
// spfd_front - input stage of the spring force block
// Accepts position beats, forms per-axis magnitudes and the squared distance.
// ----------------------------------------------------------------------------
`default_nettype none

module spfd_front (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic signed [spfd_pkg::POS_W-1:0] pos_a_x,
    input  wire logic signed [spfd_pkg::POS_W-1:0] pos_a_y,
    input  wire logic signed [spfd_pkg::POS_W-1:0] pos_b_x,
    input  wire logic signed [spfd_pkg::POS_W-1:0] pos_b_y,
    input  wire logic                              both_attached,
    output logic                                   push_valid,
    input  wire logic                              push_ready,
    output spfd_pkg::spfd_item_t                   push_item
);
    import spfd_pkg::*;

    logic                 en;
    logic [DELTA_W-1:0]   dx;
    logic [DELTA_W-1:0]   dy;
    logic                 s1_vld_reg, s2_vld_reg, s3_vld_reg;
    logic [DELTA_W-1:0]   s1_adx_reg, s1_ady_reg;
    logic                 s1_negx_reg, s1_negy_reg, s1_att_reg;
    logic [RAD_W-1:0]     s2_sqx_reg, s2_sqy_reg;
    logic [DELTA_W-1:0]   s2_adx_reg, s2_ady_reg;
    logic                 s2_negx_reg, s2_negy_reg, s2_att_reg;
    spfd_item_t           s3_item_reg;

    // Stall the whole front when the last beat cannot be pushed
    assign en       = !s3_vld_reg || push_ready;
    assign in_ready = en;

    // Signed differences B - A, one bit wider than the positions
    assign dx = {pos_b_x[POS_W-1], pos_b_x} - {pos_a_x[POS_W-1], pos_a_x};
    assign dy = {pos_b_y[POS_W-1], pos_b_y} - {pos_a_y[POS_W-1], pos_a_y};

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_vld_reg <= in_valid;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
        end
    end

    // Magnitudes, squares, then the radicand
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_negx_reg <= dx[DELTA_W-1];
            s1_negy_reg <= dy[DELTA_W-1];
            s1_adx_reg  <= dx[DELTA_W-1] ? -dx : dx;
            s1_ady_reg  <= dy[DELTA_W-1] ? -dy : dy;
            s1_att_reg  <= both_attached;

            s2_sqx_reg  <= RAD_W'(s1_adx_reg) * RAD_W'(s1_adx_reg);
            s2_sqy_reg  <= RAD_W'(s1_ady_reg) * RAD_W'(s1_ady_reg);
            s2_adx_reg  <= s1_adx_reg;
            s2_ady_reg  <= s1_ady_reg;
            s2_negx_reg <= s1_negx_reg;
            s2_negy_reg <= s1_negy_reg;
            s2_att_reg  <= s1_att_reg;

            s3_item_reg.rad  <= s2_sqx_reg + s2_sqy_reg;
            s3_item_reg.adx  <= s2_adx_reg;
            s3_item_reg.ady  <= s2_ady_reg;
            s3_item_reg.negx <= s2_negx_reg;
            s3_item_reg.negy <= s2_negy_reg;
            s3_item_reg.att  <= s2_att_reg;
        end
    end

    assign push_valid = s3_vld_reg;
    assign push_item  = s3_item_reg;

endmodule

`default_nettype wire

### rtl/core/spfd_fifo.sv
// ----------------------------------------------------------------------------
// spfd_fifo - short queue between front and back
// Lets the front keep accepting while the back is stalled, and the reverse.
// ----------------------------------------------------------------------------
`default_nettype none

module spfd_fifo (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push_valid,
    output logic                      push_ready,
    input  wire spfd_pkg::spfd_item_t push_item,
    output logic                      pop_valid,
    input  wire logic                 pop_ready,
    output spfd_pkg::spfd_item_t      pop_item
);
    import spfd_pkg::*;

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    spfd_item_t       mem [0:FIFO_DEPTH-1];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(FIFO_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_item   = mem[rd_ptr_reg];

    // Track pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (!do_push && do_pop)
                count_reg <= count_reg - 1'b1;
        end
    end

    // Store the pushed beat
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_item;
    end

endmodule

`default_nettype wire

### rtl/core/spfd_sqrt.sv
// ----------------------------------------------------------------------------
// spfd_sqrt - pipelined integer square root
// One result bit per stage over the full radicand, item carried alongside.
// ----------------------------------------------------------------------------
`default_nettype none

module spfd_sqrt (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        en,
    input  wire logic                        in_valid,
    input  wire spfd_pkg::spfd_item_t        in_item,
    output logic                             out_valid,
    output logic [spfd_pkg::ROOT_W-1:0]      out_root,
    output spfd_pkg::spfd_item_t             out_item
);
    import spfd_pkg::*;

    localparam int NSTEP = ROOT_W;

    logic [REM_W-1:0]  rem_reg  [0:NSTEP-1];
    logic [ROOT_W-1:0] root_reg [0:NSTEP-1];
    spfd_item_t        item_reg [0:NSTEP-1];
    logic [NSTEP-1:0]  vld_reg;

    genvar i;
    for (i = 0; i < NSTEP; i++)
    begin : g_step
        localparam int P = NSTEP - 1 - i;
        logic [REM_W-1:0]  rem_in, rem_sh, trial;
        logic [ROOT_W-1:0] root_in;
        spfd_item_t        item_in;
        logic              v_in;

        if (i == 0)
        begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign item_in = in_item;
            assign v_in    = in_valid;
        end
        else
        begin : g_next
            assign rem_in  = rem_reg[i-1];
            assign root_in = root_reg[i-1];
            assign item_in = item_reg[i-1];
            assign v_in    = vld_reg[i-1];
        end

        // Bring down the next pair of radicand bits and try 4*root + 1
        assign rem_sh = {rem_in[REM_W-3:0], item_in.rad[2*P+1 -: 2]};
        assign trial  = {1'b0, root_in, 2'b01};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[i] <= 1'b0;
            else if (en)
                vld_reg[i] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                item_reg[i] <= item_in;
                if (rem_sh >= trial)
                begin
                    rem_reg[i]  <= rem_sh - trial;
                    root_reg[i] <= {root_in[ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[i]  <= rem_sh;
                    root_reg[i] <= {root_in[ROOT_W-2:0], 1'b0};
                end
            end
        end
    end

    assign out_valid = vld_reg[NSTEP-1];
    assign out_root  = root_reg[NSTEP-1];
    assign out_item  = item_reg[NSTEP-1];

endmodule

`default_nettype wire

### rtl/core/spfd_back.sv
// ----------------------------------------------------------------------------
// spfd_back - force evaluation pipeline
// Distance, stretch, force magnitude, unit vector division and saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module spfd_back #(
    parameter int FRAC_BITS = spfd_pkg::FRAC_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire spfd_pkg::spfd_item_t              in_item,
    input  wire logic [spfd_pkg::CFG_W-1:0]        stiffness,
    input  wire logic [spfd_pkg::CFG_W-1:0]        rest_length,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic signed [spfd_pkg::POS_W-1:0]      impulse_a_x,
    output logic signed [spfd_pkg::POS_W-1:0]      impulse_a_y,
    output logic signed [spfd_pkg::POS_W-1:0]      impulse_b_x,
    output logic signed [spfd_pkg::POS_W-1:0]      impulse_b_y,
    output logic                                   applied
);
    import spfd_pkg::*;

    localparam int E_W   = ROOT_W + 1;                  // signed stretch
    localparam int KP_W  = CFG_W + ROOT_W;              // k * |e|
    localparam int F_W   = KP_W - FRAC_BITS;            // force magnitude
    localparam int N_W   = DELTA_W + FRAC_BITS;         // division dividend
    localparam int U_W   = FRAC_BITS + 1;               // unit component
    localparam int NDIV  = U_W;
    localparam int HI_W  = POS_W - 1 + U_W;
    localparam int LO_W  = FRAC_BITS + U_W;
    localparam int MAG_W = HI_W + 1;

    logic en;

    // Map a magnitude (at most 2^31) to a saturated signed value
    function automatic logic [POS_W-1:0] signed_sat(input logic [POS_W-1:0] mag,
                                                    input logic neg);
        logic [POS_W-1:0] r;
        begin
            if (neg)
                r = -mag;
            else if (mag[POS_W-1])
                r = {1'b0, {(POS_W-1){1'b1}}};
            else
                r = mag;
            return r;
        end
    endfunction

    // Whole back pipeline moves when the output register can take a beat
    assign en       = !out_valid || out_ready;
    assign in_ready = en;

    // ---- square root ----
    logic              sq_vld;
    logic [ROOT_W-1:0] sq_d;
    spfd_item_t        sq_item;

    spfd_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .in_item   (in_item),
        .out_valid (sq_vld),
        .out_root  (sq_d),
        .out_item  (sq_item)
    );

    // ---- stretch stage ----
    logic [E_W-1:0]     e_full;
    logic               e_vld_reg, e_nx_reg, e_ny_reg, e_live_reg;
    logic [ROOT_W-1:0]  e_d_reg, e_ae_reg;
    logic [DELTA_W-1:0] e_adx_reg, e_ady_reg;

    assign e_full = {1'b0, sq_d} - {{(E_W-CFG_W){1'b0}}, rest_length};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e_ae_reg   <= e_full[E_W-1] ? ROOT_W'(-e_full) : e_full[ROOT_W-1:0];
            e_nx_reg   <= e_full[E_W-1] ^ sq_item.negx;
            e_ny_reg   <= e_full[E_W-1] ^ sq_item.negy;
            e_live_reg <= sq_item.att && (sq_d != '0);
            e_d_reg    <= sq_d;
            e_adx_reg  <= sq_item.adx;
            e_ady_reg  <= sq_item.ady;
        end
    end

    // ---- force magnitude stage ----
    logic [KP_W-1:0]    kp;
    logic               k_vld_reg, k_nx_reg, k_ny_reg, k_live_reg;
    logic [F_W-1:0]     k_f_reg;
    logic [ROOT_W-1:0]  k_d_reg;
    logic [N_W-1:0]     k_rx_reg, k_ry_reg;

    assign kp = KP_W'(stiffness) * KP_W'(e_ae_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            k_f_reg    <= kp[KP_W-1:FRAC_BITS];
            k_d_reg    <= e_d_reg;
            k_rx_reg   <= {e_adx_reg, {FRAC_BITS{1'b0}}};
            k_ry_reg   <= {e_ady_reg, {FRAC_BITS{1'b0}}};
            k_nx_reg   <= e_nx_reg;
            k_ny_reg   <= e_ny_reg;
            k_live_reg <= e_live_reg;
        end
    end

    // ---- restoring division, one quotient bit per stage ----
    logic [N_W-1:0]    dv_rx_reg [0:NDIV-1];
    logic [N_W-1:0]    dv_ry_reg [0:NDIV-1];
    logic [U_W-1:0]    dv_qx_reg [0:NDIV-1];
    logic [U_W-1:0]    dv_qy_reg [0:NDIV-1];
    logic [F_W-1:0]    dv_f_reg  [0:NDIV-1];
    logic [ROOT_W-1:0] dv_d_reg  [0:NDIV-1];
    logic [NDIV-1:0]   dv_vld_reg, dv_nx_reg, dv_ny_reg, dv_live_reg;

    genvar s;
    for (s = 0; s < NDIV; s++)
    begin : g_div
        localparam int J = NDIV - 1 - s;
        logic [N_W-1:0]    rx_in, ry_in, dsh;
        logic [U_W-1:0]    qx_in, qy_in;
        logic [F_W-1:0]    f_in;
        logic [ROOT_W-1:0] d_in;
        logic              v_in, nx_in, ny_in, live_in;

        if (s == 0)
        begin : g_first
            assign rx_in   = k_rx_reg;
            assign ry_in   = k_ry_reg;
            assign qx_in   = '0;
            assign qy_in   = '0;
            assign f_in    = k_f_reg;
            assign d_in    = k_d_reg;
            assign v_in    = k_vld_reg;
            assign nx_in   = k_nx_reg;
            assign ny_in   = k_ny_reg;
            assign live_in = k_live_reg;
        end
        else
        begin : g_next
            assign rx_in   = dv_rx_reg[s-1];
            assign ry_in   = dv_ry_reg[s-1];
            assign qx_in   = dv_qx_reg[s-1];
            assign qy_in   = dv_qy_reg[s-1];
            assign f_in    = dv_f_reg[s-1];
            assign d_in    = dv_d_reg[s-1];
            assign v_in    = dv_vld_reg[s-1];
            assign nx_in   = dv_nx_reg[s-1];
            assign ny_in   = dv_ny_reg[s-1];
            assign live_in = dv_live_reg[s-1];
        end

        assign dsh = N_W'(d_in) << J;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_vld_reg[s] <= 1'b0;
            else if (en)
                dv_vld_reg[s] <= v_in;
        end

        // Subtract the shifted divisor where it fits and set the quotient bit
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (rx_in >= dsh)
                begin
                    dv_rx_reg[s] <= rx_in - dsh;
                    dv_qx_reg[s] <= qx_in | (U_W'(1) << J);
                end
                else
                begin
                    dv_rx_reg[s] <= rx_in;
                    dv_qx_reg[s] <= qx_in;
                end
                if (ry_in >= dsh)
                begin
                    dv_ry_reg[s] <= ry_in - dsh;
                    dv_qy_reg[s] <= qy_in | (U_W'(1) << J);
                end
                else
                begin
                    dv_ry_reg[s] <= ry_in;
                    dv_qy_reg[s] <= qy_in;
                end
                dv_f_reg[s]    <= f_in;
                dv_d_reg[s]    <= d_in;
                dv_nx_reg[s]   <= nx_in;
                dv_ny_reg[s]   <= ny_in;
                dv_live_reg[s] <= live_in;
            end
        end
    end

    // ---- product stage: f * u split at the binary point ----
    logic [F_W-1:0]       f_q;
    logic [POS_W-2:0]     f_hi;
    logic [FRAC_BITS-1:0] f_lo;
    logic                 f_big;
    logic [U_W-1:0]       ux, uy;
    logic                 m_vld_reg, m_nx_reg, m_ny_reg, m_live_reg;
    logic                 m_bigx_reg, m_bigy_reg;
    logic [HI_W-1:0]      m_hx_reg, m_hy_reg;
    logic [LO_W-1:0]      m_lx_reg, m_ly_reg;

    assign f_q   = dv_f_reg[NDIV-1];
    assign ux    = dv_qx_reg[NDIV-1];
    assign uy    = dv_qy_reg[NDIV-1];
    assign f_hi  = (POS_W-1)'(f_q >> FRAC_BITS);
    assign f_lo  = f_q[FRAC_BITS-1:0];
    assign f_big = ((f_q >> (POS_W - 1 + FRAC_BITS)) != '0);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_hx_reg   <= HI_W'(f_hi) * HI_W'(ux);
            m_hy_reg   <= HI_W'(f_hi) * HI_W'(uy);
            m_lx_reg   <= LO_W'(f_lo) * LO_W'(ux);
            m_ly_reg   <= LO_W'(f_lo) * LO_W'(uy);
            m_bigx_reg <= f_big && (ux != '0);
            m_bigy_reg <= f_big && (uy != '0);
            m_nx_reg   <= dv_nx_reg[NDIV-1];
            m_ny_reg   <= dv_ny_reg[NDIV-1];
            m_live_reg <= dv_live_reg[NDIV-1];
        end
    end

    // ---- saturate and drive the output register ----
    logic [MAG_W-1:0] magx, magy;
    logic [POS_W-1:0] capx, capy;
    logic             out_vld_reg, applied_reg;
    logic [POS_W-1:0] ax_reg, ay_reg, bx_reg, by_reg;

    assign magx = MAG_W'(m_hx_reg) + MAG_W'(m_lx_reg >> FRAC_BITS);
    assign magy = MAG_W'(m_hy_reg) + MAG_W'(m_ly_reg >> FRAC_BITS);
    assign capx = (m_bigx_reg || ((magx >> (POS_W - 1)) != '0))
                ? {1'b1, {(POS_W-1){1'b0}}} : magx[POS_W-1:0];
    assign capy = (m_bigy_reg || ((magy >> (POS_W - 1)) != '0))
                ? {1'b1, {(POS_W-1){1'b0}}} : magy[POS_W-1:0];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (m_live_reg)
            begin
                ax_reg      <= signed_sat(capx, m_nx_reg);
                ay_reg      <= signed_sat(capy, m_ny_reg);
                bx_reg      <= signed_sat(capx, !m_nx_reg);
                by_reg      <= signed_sat(capy, !m_ny_reg);
                applied_reg <= 1'b1;
            end
            else
            begin
                ax_reg      <= '0;
                ay_reg      <= '0;
                bx_reg      <= '0;
                by_reg      <= '0;
                applied_reg <= 1'b0;
            end
        end
    end

    // Advance valid bits of the scalar stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_vld_reg   <= 1'b0;
            k_vld_reg   <= 1'b0;
            m_vld_reg   <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            e_vld_reg   <= sq_vld;
            k_vld_reg   <= e_vld_reg;
            m_vld_reg   <= dv_vld_reg[NDIV-1];
            out_vld_reg <= m_vld_reg;
        end
    end

    assign out_valid   = out_vld_reg;
    assign impulse_a_x = ax_reg;
    assign impulse_a_y = ay_reg;
    assign impulse_b_x = bx_reg;
    assign impulse_b_y = by_reg;
    assign applied     = applied_reg;

endmodule

`default_nettype wire
